[sv/wwkc_pkg.sv]
`timescale 1ns / 1ps

package wwkc_pkg;

  // Configuration register indexes.
  typedef logic [2:0] cfg_index_t;

  localparam cfg_index_t CFG_KEYWORD_LENGTH  = 3'd0;
  localparam cfg_index_t CFG_KEYWORD_CHARS_0 = 3'd1;
  localparam cfg_index_t CFG_KEYWORD_CHARS_1 = 3'd2;
  localparam cfg_index_t CFG_KEYWORD_CHARS_2 = 3'd3;
  localparam cfg_index_t CFG_KEYWORD_CHARS_3 = 3'd4;

  // Keyword storage layout.
  localparam int unsigned CHAR_REGS     = 4;
  localparam int unsigned CHARS_PER_REG = 8;
  localparam int unsigned KEY_CHARS     = CHAR_REGS * CHARS_PER_REG;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned LENGTH_W      = 6;

  typedef logic [CFG_DATA_W-1:0] chars_reg_t;

  // State passed from one cell to the next: a partial match and whether
  // the byte in front of its first character is a letter of the token.
  typedef struct packed {
    logic match;
    logic left_letter;
  } link_t;

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  function automatic logic is_separator(input logic [7:0] b);
    return ((b >= 8'h09) && (b <= 8'h0D)) || (b == 8'h20);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'h20) : b;
  endfunction

endpackage

[sv/wwkc_cell.sv]
`timescale 1ns / 1ps

// One cell of the matching row: tracks whether the keyword prefix that
// ends at its position matches the bytes seen so far in the token.
module wwkc_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_en_i,
  input  logic            flush_en_i,
  input  logic [7:0]      byte_lc_i,
  input  logic [7:0]      expected_i,
  input  wwkc_pkg::link_t link_i,
  output wwkc_pkg::link_t step_o,
  output wwkc_pkg::link_t link_o
);

  wwkc_pkg::link_t link_d, link_q;

  // Value this cell takes on when the current byte joins the token.
  always_comb begin
    step_o.match       = link_i.match && (byte_lc_i == expected_i);
    step_o.left_letter = link_i.left_letter;
  end

  // A token end clears the cell; a token byte moves the chain along.
  always_comb begin
    link_d = link_q;
    if (flush_en_i) begin
      link_d = '0;
    end else if (step_en_i) begin
      link_d = step_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q <= link_d;
    end
  end

  assign link_o = link_q;

endmodule

[sv/whole_word_keyword_counter.sv]
`timescale 1ns / 1ps

// Whole-word keyword counter. Text arrives one byte per transaction. The
// block takes one byte every clock cycle as long as the count output is not
// held back; while a finished count waits to be taken, the input stalls. A
// row of MAX_KEYWORD cells, one per keyword character, tracks every partial
// match inside the current token and moves one place per byte, so each byte
// is judged in the cycle it is accepted. Letters are compared without
// regard to case, bytes 9 to 13 and 32 separate tokens, and only the
// leftmost occurrence in a token counts, when neither neighbor is a letter
// of the token. The count appears in the cycle after the byte marked
// end_of_text is accepted; it saturates at 2^COUNT_WIDTH - 1 and clears for
// the next text. There is no clearing pass after reset, and configuration
// must be written only while the block is idle.
module whole_word_keyword_counter #(
  parameter int unsigned MAX_KEYWORD = 32,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  wwkc_pkg::cfg_index_t           cfg_index_i,
  input  logic [wwkc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Text input.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     text_byte_i,
  input  logic                           end_of_text_i,
  // Count output.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [31:0]                    keyword_total_o
);

  localparam int unsigned LEN_W = wwkc_pkg::LENGTH_W + 1;

  // Configuration registers.
  logic [wwkc_pkg::LENGTH_W-1:0] keyword_length_q;
  wwkc_pkg::chars_reg_t          keyword_chars_q [wwkc_pkg::CHAR_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keyword_length_q <= wwkc_pkg::LENGTH_W'(1);
      for (int r = 0; r < wwkc_pkg::CHAR_REGS; r++) begin
        keyword_chars_q[r] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wwkc_pkg::CFG_KEYWORD_LENGTH:  keyword_length_q   <= cfg_data_i[wwkc_pkg::LENGTH_W-1:0];
        wwkc_pkg::CFG_KEYWORD_CHARS_0: keyword_chars_q[0] <= cfg_data_i;
        wwkc_pkg::CFG_KEYWORD_CHARS_1: keyword_chars_q[1] <= cfg_data_i;
        wwkc_pkg::CFG_KEYWORD_CHARS_2: keyword_chars_q[2] <= cfg_data_i;
        wwkc_pkg::CFG_KEYWORD_CHARS_3: keyword_chars_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective keyword length, limited to the number of cells.
  logic [LEN_W-1:0] len_eff;
  assign len_eff = ({1'b0, keyword_length_q} > LEN_W'(MAX_KEYWORD)) ?
                   LEN_W'(MAX_KEYWORD) : {1'b0, keyword_length_q};

  // Handshake and decoded input byte.
  logic       in_fire;
  logic       out_fire;
  logic       sep;
  logic       letter;
  logic [7:0] byte_lc;
  logic       step_en;
  logic       flush_en;

  assign in_ready_o = !out_valid_o || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_o && out_ready_i;
  assign sep        = wwkc_pkg::is_separator(text_byte_i);
  assign letter     = wwkc_pkg::is_letter(text_byte_i);
  assign byte_lc    = wwkc_pkg::to_lower(text_byte_i);
  assign step_en    = in_fire && !sep && !end_of_text_i;
  assign flush_en   = in_fire && (sep || end_of_text_i);

  // Letter status of the previous byte in this token.
  logic prev_letter_q;

  // Row of matching cells.
  wwkc_pkg::link_t chain_in  [MAX_KEYWORD];
  wwkc_pkg::link_t chain_q   [MAX_KEYWORD];
  wwkc_pkg::link_t chain_stp [MAX_KEYWORD];
  logic [MAX_KEYWORD-1:0] end_match;
  logic [MAX_KEYWORD-1:0] end_left;

  for (genvar i = 0; i < MAX_KEYWORD; i++) begin : g_cell
    logic [7:0] expected;

    if (i < wwkc_pkg::KEY_CHARS) begin : g_key
      assign expected = wwkc_pkg::to_lower(
        keyword_chars_q[i / wwkc_pkg::CHARS_PER_REG]
                       [8*(i % wwkc_pkg::CHARS_PER_REG) +: 8]);
    end else begin : g_zero
      assign expected = 8'h00;
    end

    if (i == 0) begin : g_head
      assign chain_in[i] = '{match: 1'b1, left_letter: prev_letter_q};
    end else begin : g_body
      assign chain_in[i] = chain_q[i-1];
    end

    wwkc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_en_i  (step_en),
      .flush_en_i (flush_en),
      .byte_lc_i  (byte_lc),
      .expected_i (expected),
      .link_i     (chain_in[i]),
      .step_o     (chain_stp[i]),
      .link_o     (chain_q[i])
    );

    // Only the cell at the keyword's last character reports a full match.
    assign end_match[i] = chain_stp[i].match && (len_eff == LEN_W'(i + 1));
    assign end_left[i]  = chain_stp[i].left_letter && (len_eff == LEN_W'(i + 1));
  end

  logic full_match;
  logic left_bad;
  assign full_match = |end_match;
  assign left_bad   = |end_left;

  // Token bookkeeping and count update.
  logic                   settled_q, settled_d;
  logic                   pending_q, pending_d;
  logic                   prev_letter_d;
  logic                   bump;
  logic                   found;
  logic [COUNT_WIDTH-1:0] total_q, total_d, total_inc;
  logic                   out_valid_q, out_valid_d;
  logic [31:0]            out_total_q, out_total_d;

  always_comb begin
    found     = 1'b0;
    bump      = 1'b0;
    settled_d = settled_q;
    pending_d = pending_q;
    if (sep) begin
      bump      = pending_q;
      settled_d = 1'b0;
      pending_d = 1'b0;
    end else begin
      bump      = pending_q && !letter;
      found     = !settled_q && full_match;
      settled_d = settled_q || found;
      pending_d = found && !left_bad;
    end
    // The last byte also ends the token.
    if (end_of_text_i) begin
      bump      = bump || pending_d;
      settled_d = 1'b0;
      pending_d = 1'b0;
    end
    prev_letter_d = (sep || end_of_text_i) ? 1'b0 : letter;
    total_inc     = (bump && (total_q != '1)) ? total_q + COUNT_WIDTH'(1) : total_q;
  end

  // Result register: loads on the last byte, empties when taken.
  always_comb begin
    total_d     = total_q;
    out_valid_d = out_valid_q;
    out_total_d = out_total_q;
    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      if (end_of_text_i) begin
        total_d     = '0;
        out_valid_d = 1'b1;
        out_total_d = 32'(total_inc);
      end else begin
        total_d = total_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settled_q     <= 1'b0;
      pending_q     <= 1'b0;
      prev_letter_q <= 1'b0;
      total_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        settled_q     <= settled_d;
        pending_q     <= pending_d;
        prev_letter_q <= prev_letter_d;
      end
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_total_q <= out_total_d;
  end

  assign out_valid_o     = out_valid_q;
  assign keyword_total_o = out_total_q;

endmodule
